>>> sv/iapm_pkg.sv
// Shared types and constants for the I2C address probe master.
// No dependencies; used by iapm_seq and i2c_address_probe_master_top.
package iapm_pkg;

    // Input beat: one half-bit tick with line samples and an optional command
    typedef struct packed {
        logic [1:0] command;
        logic [6:0] target_address;
        logic       scl_level;
        logic       sda_level;
    } in_t;

    // Result beat: line drives, status and last outcome
    typedef struct packed {
        logic       scl_pull_low;
        logic       sda_pull_low;
        logic       busy_res;
        logic       done_res;
        logic [1:0] outcome;
    } out_t;

    // Command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_PROBE = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Outcome codes
    localparam logic [1:0] OUT_ACK   = 2'd0;
    localparam logic [1:0] OUT_NACK  = 2'd1;
    localparam logic [1:0] OUT_BUSY  = 2'd2;
    localparam logic [1:0] OUT_STUCK = 2'd3;

    // Sequencer phases
    localparam logic [4:0] PH_IDLE       = 5'd0;
    localparam logic [4:0] PH_CHECK      = 5'd1;
    localparam logic [4:0] PH_START_HOLD = 5'd2;
    localparam logic [4:0] PH_BIT_LOW    = 5'd3;
    localparam logic [4:0] PH_BIT_WAIT   = 5'd4;
    localparam logic [4:0] PH_BIT_HIGH   = 5'd5;
    localparam logic [4:0] PH_ACK_LOW    = 5'd6;
    localparam logic [4:0] PH_ACK_WAIT   = 5'd7;
    localparam logic [4:0] PH_ACK_HIGH   = 5'd8;
    localparam logic [4:0] PH_STOP_LOW   = 5'd9;
    localparam logic [4:0] PH_STOP_WAIT  = 5'd10;
    localparam logic [4:0] PH_STOP_HIGH  = 5'd11;
    localparam logic [4:0] PH_STOP_END   = 5'd12;
    localparam logic [4:0] PH_CLR_LOW    = 5'd13;
    localparam logic [4:0] PH_CLR_WAIT   = 5'd14;
    localparam logic [4:0] PH_CLR_HIGH   = 5'd15;
    localparam logic [4:0] PH_CSTOP_LOW  = 5'd16;
    localparam logic [4:0] PH_CSTOP_WAIT = 5'd17;
    localparam logic [4:0] PH_CSTOP_HIGH = 5'd18;

    // SCL pulses given by a bus clear
    localparam logic [3:0] CLEAR_PULSES = 4'd9;

    // Clock-stretch budget after reset, in ticks
    localparam logic [15:0] BUDGET_RESET = 16'd64;

endpackage

>>> sv/i2c_address_probe_master_top.sv
// An accepted input beat goes through the input register, then the step logic into
// the result register. Throughput: one beat per cycle unless the result slot stalls;
// the sequencer step is a single pass.
// Reset (rst_n, async low): sequencer idle, lines released, outcome ack,
// stretch budget 64, both pipeline registers empty.
// Top level of the I2C address probe master; depends on iapm_pkg and iapm_seq.
module i2c_address_probe_master_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  iapm_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output iapm_pkg::out_t out_data,
    input  logic           cfg_we,
    input  logic [15:0]    cfg_wdata
);

    logic           in_valid_reg;
    iapm_pkg::in_t  in_data_reg;
    logic           out_valid_reg;
    iapm_pkg::out_t out_data_reg;
    logic [15:0]    budget_reg;
    logic           out_free;
    logic           fire;
    iapm_pkg::out_t step_res;

    // Handshake: step fires when the result slot is free
    assign out_free = !out_valid_reg || out_ready;
    assign fire     = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || fire;

    // Stretch budget register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            budget_reg <= iapm_pkg::BUDGET_RESET;
        else if (cfg_we)
            budget_reg <= cfg_wdata;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_data_reg <= in_data;
    end

    iapm_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .beat   (in_data_reg),
        .budget (budget_reg),
        .res    (step_res)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= fire;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            out_data_reg <= step_res;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A done beat never shows busy
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.done_res |-> !out_data_reg.busy_res)
        else $error("done and busy together");

    // A stalled result slot blocks the step
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !fire)
        else $error("step fired into a full result slot");

    // Each step yields one result beat
    a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("step lost its result");

endmodule

>>> sv/iapm_seq.sv
// Probe / bus-clear sequencer: state registers plus the one-tick step logic.
// Depends on iapm_pkg.
module iapm_seq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           fire,
    input  iapm_pkg::in_t  beat,
    input  logic [15:0]    budget,
    output iapm_pkg::out_t res
);

    logic [4:0]  phase_reg, phase_next;
    logic [3:0]  bit_index_reg, bit_index_next;
    logic [7:0]  shift_byte_reg, shift_byte_next;
    logic [15:0] wait_count_reg, wait_count_next;
    logic [3:0]  pulse_count_reg, pulse_count_next;
    logic        scl_drive_reg, scl_drive_next;
    logic        sda_drive_reg, sda_drive_next;
    logic        ack_seen_reg, ack_seen_next;
    logic [1:0]  outcome_reg, outcome_next;

    logic        done;
    logic        timeout;
    logic [3:0]  bit_dec;
    logic [3:0]  pulse_inc;

    assign timeout   = (wait_count_reg >= budget);
    assign bit_dec   = bit_index_reg - 4'd1;
    assign pulse_inc = pulse_count_reg + 4'd1;

    // One step of the sequencer for the current beat
    always_comb
    begin
        phase_next       = phase_reg;
        bit_index_next   = bit_index_reg;
        shift_byte_next  = shift_byte_reg;
        wait_count_next  = wait_count_reg;
        pulse_count_next = pulse_count_reg;
        scl_drive_next   = scl_drive_reg;
        sda_drive_next   = sda_drive_reg;
        ack_seen_next    = ack_seen_reg;
        outcome_next     = outcome_reg;
        done             = 1'b0;

        case (phase_reg)
            iapm_pkg::PH_IDLE:
            begin
                if (beat.command == iapm_pkg::CMD_PROBE)
                begin
                    scl_drive_next  = 1'b0;
                    sda_drive_next  = 1'b0;
                    shift_byte_next = {beat.target_address, 1'b0};
                    phase_next      = iapm_pkg::PH_CHECK;
                end
                else if (beat.command == iapm_pkg::CMD_CLEAR)
                begin
                    sda_drive_next   = 1'b0;
                    scl_drive_next   = 1'b1;
                    pulse_count_next = 4'd0;
                    phase_next       = iapm_pkg::PH_CLR_LOW;
                end
            end
            // Lines released: check for stuck clock or busy bus
            iapm_pkg::PH_CHECK:
            begin
                if (!beat.scl_level)
                begin
                    outcome_next = iapm_pkg::OUT_STUCK;
                    done         = 1'b1;
                end
                else if (!beat.sda_level)
                begin
                    outcome_next = iapm_pkg::OUT_BUSY;
                    done         = 1'b1;
                end
                else
                begin
                    sda_drive_next = 1'b1;
                    phase_next     = iapm_pkg::PH_START_HOLD;
                end
            end
            iapm_pkg::PH_START_HOLD:
            begin
                scl_drive_next = 1'b1;
                bit_index_next = 4'd7;
                sda_drive_next = ~shift_byte_reg[7];
                phase_next     = iapm_pkg::PH_BIT_LOW;
            end
            // Release SCL and arm the stretch counter
            iapm_pkg::PH_BIT_LOW, iapm_pkg::PH_ACK_LOW, iapm_pkg::PH_STOP_LOW,
            iapm_pkg::PH_CLR_LOW, iapm_pkg::PH_CSTOP_LOW:
            begin
                scl_drive_next  = 1'b0;
                wait_count_next = 16'd0;
                phase_next      = phase_reg + 5'd1;
            end
            // Clock-high wait inside the address frame: timeout aborts
            iapm_pkg::PH_BIT_WAIT, iapm_pkg::PH_ACK_WAIT:
            begin
                if (timeout)
                begin
                    scl_drive_next = 1'b0;
                    sda_drive_next = 1'b0;
                    outcome_next   = iapm_pkg::OUT_STUCK;
                    done           = 1'b1;
                end
                else if (beat.scl_level)
                begin
                    if (phase_reg == iapm_pkg::PH_ACK_WAIT)
                        ack_seen_next = ~beat.sda_level;
                    phase_next = phase_reg + 5'd1;
                end
                else
                begin
                    wait_count_next = wait_count_reg + 16'd1;
                end
            end
            iapm_pkg::PH_BIT_HIGH:
            begin
                scl_drive_next = 1'b1;
                if (bit_index_reg == 4'd0)
                begin
                    sda_drive_next = 1'b0;
                    phase_next     = iapm_pkg::PH_ACK_LOW;
                end
                else
                begin
                    bit_index_next = bit_dec;
                    sda_drive_next = ~shift_byte_reg[bit_dec[2:0]];
                    phase_next     = iapm_pkg::PH_BIT_LOW;
                end
            end
            iapm_pkg::PH_ACK_HIGH:
            begin
                scl_drive_next = 1'b1;
                sda_drive_next = 1'b1;
                phase_next     = iapm_pkg::PH_STOP_LOW;
            end
            // STOP and bus-clear waits: timeout counts as SCL high
            iapm_pkg::PH_STOP_WAIT, iapm_pkg::PH_CLR_WAIT, iapm_pkg::PH_CSTOP_WAIT:
            begin
                if (timeout || beat.scl_level)
                    phase_next = phase_reg + 5'd1;
                else
                    wait_count_next = wait_count_reg + 16'd1;
            end
            iapm_pkg::PH_STOP_HIGH:
            begin
                sda_drive_next = 1'b0;
                phase_next     = iapm_pkg::PH_STOP_END;
            end
            iapm_pkg::PH_STOP_END:
            begin
                outcome_next = ack_seen_reg ? iapm_pkg::OUT_ACK : iapm_pkg::OUT_NACK;
                done         = 1'b1;
            end
            iapm_pkg::PH_CLR_HIGH:
            begin
                pulse_count_next = pulse_inc;
                scl_drive_next   = 1'b1;
                if (pulse_inc < iapm_pkg::CLEAR_PULSES)
                begin
                    phase_next = iapm_pkg::PH_CLR_LOW;
                end
                else
                begin
                    sda_drive_next = 1'b1;
                    phase_next     = iapm_pkg::PH_CSTOP_LOW;
                end
            end
            iapm_pkg::PH_CSTOP_HIGH:
            begin
                sda_drive_next = 1'b0;
                done           = 1'b1;
            end
            default:
            begin
                phase_next = iapm_pkg::PH_IDLE;
            end
        endcase

        if (done)
            phase_next = iapm_pkg::PH_IDLE;
    end

    // Result of this step
    assign res.scl_pull_low = scl_drive_next;
    assign res.sda_pull_low = sda_drive_next;
    assign res.busy_res     = (phase_next != iapm_pkg::PH_IDLE);
    assign res.done_res     = done;
    assign res.outcome      = outcome_next;

    // State registers advance once per accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= iapm_pkg::PH_IDLE;
            bit_index_reg   <= 4'd0;
            shift_byte_reg  <= 8'd0;
            wait_count_reg  <= 16'd0;
            pulse_count_reg <= 4'd0;
            scl_drive_reg   <= 1'b0;
            sda_drive_reg   <= 1'b0;
            ack_seen_reg    <= 1'b0;
            outcome_reg     <= iapm_pkg::OUT_ACK;
        end
        else if (fire)
        begin
            phase_reg       <= phase_next;
            bit_index_reg   <= bit_index_next;
            shift_byte_reg  <= shift_byte_next;
            wait_count_reg  <= wait_count_next;
            pulse_count_reg <= pulse_count_next;
            scl_drive_reg   <= scl_drive_next;
            sda_drive_reg   <= sda_drive_next;
            ack_seen_reg    <= ack_seen_next;
            outcome_reg     <= outcome_next;
        end
    end

    // A finished sequence returns to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.done_res |=> phase_reg == iapm_pkg::PH_IDLE)
        else $error("phase not idle after done");

    // Phase moves only on an accepted beat
    a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(phase_reg))
        else $error("phase changed without a beat");

    // Clock low at the line check reports stuck
    a_check_stuck: assert property (@(posedge clk) disable iff (!rst_n)
        fire && phase_reg == iapm_pkg::PH_CHECK && !beat.scl_level
        |-> res.done_res && res.outcome == iapm_pkg::OUT_STUCK)
        else $error("stuck clock not reported");

endmodule
